// ===== hw/rtl/humidity_temp_frame_decoder_top_defines.svh =====
// assertion macros for the frame decoder
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH

// check a property on every clock edge outside reset
`define HTFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("htfd assertion failed");

// check a property on every clock edge, reset included
`define HTFD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("htfd assertion failed");

`else

`define HTFD_ASSERT(lbl, clk, rst_n, prop)
`define HTFD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/htfd_pkg.sv =====
package htfd_pkg;

    // crc-8 over the sensor words
    localparam logic [7:0] CrcInit = 8'hFF;
    localparam logic [7:0] CrcPoly = 8'h31;

    // scaling constants, results are round(value / 65535)
    localparam logic [7:0]  TempSpan     = 8'd175;
    localparam logic [24:0] TempOffset   = 25'd2949075;  // 45 * 65535
    localparam logic [6:0]  HumSpan      = 7'd100;
    localparam logic [15:0] HalfScale    = 16'd32767;    // rounding bias

    // one frame from the sensor
    typedef struct packed {
        logic [7:0] temp_msb;
        logic [7:0] temp_lsb;
        logic [7:0] temp_check;
        logic [7:0] hum_msb;
        logic [7:0] hum_lsb;
        logic [7:0] hum_check;
    } frame_t;

    // one decoded result
    typedef struct packed {
        logic signed [8:0] temp_celsius;
        logic [7:0]        temp_byte;
        logic [6:0]        humidity_pct;
        logic              temp_crc_ok;
        logic              hum_crc_ok;
    } result_t;

    // one byte through the crc, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (crc[7])
                crc = {crc[6:0], 1'b0} ^ CrcPoly;
            else
                crc = {crc[6:0], 1'b0};
        end
        return crc;
    endfunction

    // crc over a word, high byte first
    function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
        return crc8_byte(crc8_byte(CrcInit, hi), lo);
    endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_decoder_top.sv =====
// Decodes one six-byte humidity/temperature frame per item: both check bytes are
// compared with CRC-8 (poly 0x31, init 0xFF) over their words, temperature is
// scaled to round(-45 + 175*raw/65535) C and humidity to round(100*raw/65535) %.
// An item is registered on entry, decoded combinationally and held in the result
// register; one frame is taken every cycle while the result side does not stall.
// The divisions by 65535 are exact, done with an add-and-shift identity after a
// constant multiply; a bad check byte only clears its ok flag, the values are
// still given.
`include "humidity_temp_frame_decoder_top_defines.svh"

module humidity_temp_frame_decoder_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    output logic             frame_stall,
    input  htfd_pkg::frame_t frame,
    output logic             result_valid,
    input  logic             result_stall,
    output htfd_pkg::result_t result
);
    import htfd_pkg::*;

    logic    in_valid_reg;
    frame_t  in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t out_data_next;

    logic out_load;
    logic in_load;

    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic [23:0] prod_t;
    logic [24:0] num_t;
    logic        temp_neg;
    logic [23:0] mag_t;
    logic [23:0] biased_t;
    logic [24:0] sum_t;
    logic [7:0]  quot_t;
    logic [8:0]  temp_val;
    logic [22:0] prod_h;
    logic [22:0] biased_h;
    logic [23:0] sum_h;

    // pipeline moves
    assign out_load    = !out_valid_reg || !result_stall;
    assign in_load     = !in_valid_reg || out_load;
    assign frame_stall = !in_load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_load)
            in_valid_reg <= frame_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_load && frame_valid)
            in_data_reg <= frame;
    end

    // temperature: |175*raw - 45*65535| rounded over 65535, sign put back
    always_comb
    begin
        raw_t    = {in_data_reg.temp_msb, in_data_reg.temp_lsb};
        prod_t   = 24'(raw_t) * 24'(TempSpan);
        num_t    = {1'b0, prod_t} - TempOffset;
        temp_neg = num_t[24];
        mag_t    = temp_neg ? 24'(-num_t) : num_t[23:0];
        biased_t = mag_t + 24'(HalfScale);
        sum_t    = 25'(biased_t) + 25'(biased_t[23:16]) + 25'd1;
        quot_t   = sum_t[23:16];
        temp_val = temp_neg ? 9'(-{1'b0, quot_t}) : {1'b0, quot_t};
    end

    // humidity: 100*raw rounded over 65535
    always_comb
    begin
        raw_h    = {in_data_reg.hum_msb, in_data_reg.hum_lsb};
        prod_h   = 23'(raw_h) * 23'(HumSpan);
        biased_h = prod_h + 23'(HalfScale);
        sum_h    = 24'(biased_h) + 24'(biased_h[22:16]) + 24'd1;
    end

    // result assembly
    always_comb
    begin
        out_data_next.temp_celsius = $signed(temp_val);
        out_data_next.temp_byte    = temp_val[7:0];
        out_data_next.humidity_pct = sum_h[22:16];
        out_data_next.temp_crc_ok  =
            (crc8_word(in_data_reg.temp_msb, in_data_reg.temp_lsb) == in_data_reg.temp_check);
        out_data_next.hum_crc_ok   =
            (crc8_word(in_data_reg.hum_msb, in_data_reg.hum_lsb) == in_data_reg.hum_check);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
            out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // checks
    `HTFD_ASSERT(a_stall_only_when_full, clk, rst_n,
        frame_stall |-> (in_valid_reg && out_valid_reg && result_stall))
    `HTFD_ASSERT(a_item_advances, clk, rst_n, (in_valid_reg && out_load) |=> out_valid_reg)
    `HTFD_ASSERT(a_temp_range, clk, rst_n,
        out_valid_reg |-> (($signed(out_data_reg.temp_celsius) >= -45) &&
                           ($signed(out_data_reg.temp_celsius) <= 130)))
    `HTFD_ASSERT(a_hum_range, clk, rst_n, out_valid_reg |-> (out_data_reg.humidity_pct <= 7'd100))
    `HTFD_ASSERT(a_byte_matches, clk, rst_n,
        out_valid_reg |-> (out_data_reg.temp_byte == out_data_reg.temp_celsius[7:0]))
    `HTFD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!in_valid_reg && !out_valid_reg))

endmodule
